### sv/jvcs_pkg.sv
// Shared types, register indexes and helper functions of the joystick command shaper.
package jvcs_pkg;

  localparam int unsigned AxisW = 16;
  localparam int unsigned MulW  = 18;
  localparam int unsigned AccW  = 37;

  typedef enum logic [2:0] {
    REG_VX_FAST = 3'd0,
    REG_VX_SLOW = 3'd1,
    REG_VY      = 3'd2,
    REG_YAW     = 3'd3,
    REG_SMOOTH  = 3'd4,
    REG_DZ      = 3'd5
  } reg_idx_e;

  localparam logic [14:0] DeadZoneRst = 15'd3277;

  typedef enum logic [1:0] {
    AX_FWD  = 2'd0,
    AX_SIDE = 2'd1,
    AX_TURN = 2'd2
  } axis_e;

  typedef struct packed {
    logic [31:0] vx_fast;
    logic [31:0] vx_slow;
    logic [31:0] vy;
    logic [31:0] yaw;
    logic [15:0] smooth;
    logic [14:0] dead_zone;
  } cfg_t;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic accum;
  } mac_ctl_t;

  // |stick| <= dead zone, with |-1.0| taken as 32768
  function automatic logic centred(logic signed [AxisW-1:0] s, logic [14:0] dz);
    logic [16:0] m;
    m = s[15] ? (17'd0 - {s[15], s}) : {1'b0, s};
    return m <= {2'b00, dz};
  endfunction

  function automatic logic signed [AxisW-1:0] sat16(logic signed [20:0] v);
    logic signed [AxisW-1:0] r;
    if (v > 21'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -21'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### sv/joystick_velocity_command_shaper.sv
// Top level: sequencer of the joystick dead-zone, scaling and smoothing shaper.
//
// Input stream: s_axis_tdata carries the forward, side and turn sticks (Q1.15),
// s_axis_tuser the high-speed flag. Output stream: m_axis_tdata carries the
// smoothed vx, vy and yaw commands (Q3.12), m_axis_tuser the armed flag.
// Limits, smoothing and dead zone come in through the cfg_* write port.
// Each axis takes three passes through one shared multiplier: stick times
// limit, request times (1 - s), previous command times s. An armed request
// therefore steps through ST_REQ, ST_BLEND and ST_PREV for each axis and then
// ST_FIN; while not armed the block answers with zero commands from ST_ZERO.
// A new request is taken only once the last result is in the output register.
// The block takes a request only in its idle state. A finished result sits in
// the output register; the next request is processed while it waits, and the
// sequencer holds its last step until the register is free.
// Reset clears the armed flag and the previous commands, drops any pending
// result and sets the dead zone to 3277 and all other config registers to zero.
module joystick_velocity_command_shaper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // stick_forward, stick_side, stick_turn
  input  logic [0:0]  s_axis_tuser,   // high_speed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // cmd_vx, cmd_vy, cmd_yaw
  output logic [0:0]  m_axis_tuser,   // is_armed
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import jvcs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_REQ   = 6'b000010,
    ST_BLEND = 6'b000100,
    ST_PREV  = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_ZERO  = 6'b100000
  } state_e;

  cfg_t     cfg;
  mac_ctl_t mac_ctl;
  logic signed [MulW-1:0] mac_a, mac_b;
  logic signed [AccW-1:0] acc;

  state_e state_q, state_d;
  logic [1:0] ax_q, ax_d;
  logic armed_q, armed_d;
  logic signed [AxisW-1:0] prev_q [3];
  logic signed [AxisW-1:0] stick_q [3];
  logic hs_q;

  logic m_valid_q, m_valid_d;
  logic [47:0] m_data_q, m_data_d;
  logic m_user_q, m_user_d;

  logic in_fire, out_free;
  logic signed [AxisW-1:0] stick_sel, prev_sel, wb_val;
  logic [31:0] range_sel;
  logic [15:0] mag_sel;
  logic signed [16:0] req;
  logic [16:0] one_minus_s;
  logic wb_en;
  logic [1:0] wb_idx;

  jvcs_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  jvcs_mac u_mac (
    .clk_i(clk_i),
    .ctl_i(mac_ctl),
    .a_i  (mac_a),
    .b_i  (mac_b),
    .acc_o(acc)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    case (ax_q)
      AX_FWD:  range_sel = hs_q ? cfg.vx_fast : cfg.vx_slow;
      AX_SIDE: range_sel = cfg.vy;
      default: range_sel = cfg.yaw;
    endcase
  end

  assign stick_sel   = stick_q[ax_q];
  assign prev_sel    = prev_q[ax_q];
  assign mag_sel     = stick_sel[15] ? range_sel[15:0] : range_sel[31:16];
  // request = stick * mag >>> 15, zero inside the dead zone
  assign req         = centred(stick_sel, cfg.dead_zone) ? 17'sd0 : acc[31:15];
  assign one_minus_s = 17'h10000 - {1'b0, cfg.smooth};
  assign wb_val      = sat16(acc[36:16]);

  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    case (state_q)
      ST_REQ: begin
        mac_ctl.en = 1'b1;
        mac_a      = MulW'(stick_sel);
        mac_b      = {2'b00, mag_sel};
      end
      ST_BLEND: begin
        mac_ctl.en = 1'b1;
        mac_a      = MulW'(req);
        mac_b      = {1'b0, one_minus_s};
      end
      ST_PREV: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_a         = MulW'(prev_sel);
        mac_b         = {2'b00, cfg.smooth};
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  // write back the finished axis while the next one starts
  assign wb_en  = ((state_q == ST_REQ) && (ax_q != AX_FWD)) ||
                  ((state_q == ST_FIN) && out_free);
  assign wb_idx = (state_q == ST_FIN) ? AX_TURN : ax_q - 2'd1;

  always_comb begin
    state_d   = state_q;
    ax_d      = ax_q;
    armed_d   = armed_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ax_d = AX_FWD;
          if (armed_q) begin
            state_d = ST_REQ;
          end else begin
            armed_d = centred(s_axis_tdata[15:0], cfg.dead_zone) &&
                      centred(s_axis_tdata[31:16], cfg.dead_zone) &&
                      centred(s_axis_tdata[47:32], cfg.dead_zone);
            state_d = ST_ZERO;
          end
        end
      end
      ST_REQ:   state_d = ST_BLEND;
      ST_BLEND: state_d = ST_PREV;
      ST_PREV: begin
        if (ax_q == AX_TURN) begin
          state_d = ST_FIN;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = ST_REQ;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {wb_val, prev_q[1], prev_q[0]};
          m_user_d  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = '0;
          m_user_d  = armed_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ax_q      <= AX_FWD;
      armed_q   <= 1'b0;
      m_valid_q <= 1'b0;
      prev_q[0] <= '0;
      prev_q[1] <= '0;
      prev_q[2] <= '0;
    end else begin
      state_q   <= state_d;
      ax_q      <= ax_d;
      armed_q   <= armed_d;
      m_valid_q <= m_valid_d;
      if (in_fire && !armed_q) begin
        prev_q[0] <= '0;
        prev_q[1] <= '0;
        prev_q[2] <= '0;
      end else if (wb_en) begin
        prev_q[wb_idx] <= wb_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stick_q[0] <= s_axis_tdata[15:0];
      stick_q[1] <= s_axis_tdata[31:16];
      stick_q[2] <= s_axis_tdata[47:32];
      hs_q       <= s_axis_tuser[0];
    end
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

### sv/jvcs_cfg.sv
// Configuration register file of the joystick command shaper.
module jvcs_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output jvcs_pkg::cfg_t      cfg_o
);
  import jvcs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VX_FAST: cfg_d.vx_fast   = cfg_data_i;
        REG_VX_SLOW: cfg_d.vx_slow   = cfg_data_i;
        REG_VY:      cfg_d.vy        = cfg_data_i;
        REG_YAW:     cfg_d.yaw       = cfg_data_i;
        REG_SMOOTH:  cfg_d.smooth    = cfg_data_i[15:0];
        REG_DZ:      cfg_d.dead_zone = cfg_data_i[14:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{vx_fast: '0, vx_slow: '0, vy: '0, yaw: '0, smooth: '0,
                 dead_zone: DeadZoneRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/jvcs_mac.sv
// Shared 18x18 signed multiplier with a registered accumulator.
module jvcs_mac (
  input  logic                                clk_i,
  input  jvcs_pkg::mac_ctl_t                  ctl_i,
  input  logic signed [jvcs_pkg::MulW-1:0]    a_i,
  input  logic signed [jvcs_pkg::MulW-1:0]    b_i,
  output logic signed [jvcs_pkg::AccW-1:0]    acc_o
);
  import jvcs_pkg::*;

  logic signed [2*MulW-1:0] prod;
  logic signed [AccW-1:0]   acc_q, acc_d;

  assign prod  = a_i * b_i;
  assign acc_d = (ctl_i.accum ? acc_q : '0) + AccW'(prod);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
